[sv/fccw_pkg.sv]
// ----------------------------------------------------------------------------
// FAT32 cluster chain walker package
// Shared types, codes and constants of the cluster chain sector walker.
// ----------------------------------------------------------------------------
package fccw_pkg;

  localparam logic [7:0]  MAX_CLUSTER_SECTORS  = 8'd128;
  localparam int unsigned FAT_WORDS_PER_SECTOR = 128;
  localparam int unsigned WORD_IDX_W           = $clog2(FAT_WORDS_PER_SECTOR);
  localparam int unsigned FAT_IDX_W            = 28 - WORD_IDX_W;

  localparam logic [27:0] EOC_MIN      = 28'hffffff8;
  localparam logic [27:0] BAD_MARK     = 28'hffffff7;
  localparam logic [27:0] MIN_CLUSTER  = 28'h0000002;
  localparam logic [31:0] CLUSTER_BASE = 32'h00000002;

  localparam int unsigned S_TDATA_W = 128;
  localparam int unsigned M_TDATA_W = 120;

  typedef enum logic [2:0] {
    OP_OPEN   = 3'd0,
    OP_READ   = 3'd1,
    OP_SEEK   = 3'd2,
    OP_REPLY  = 3'd3,
    OP_REWIND = 3'd4,
    OP_SIZE   = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    KIND_READ   = 2'd0,
    KIND_LOOKUP = 2'd1,
    KIND_DONE   = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_FILE = 2'd1,
    ST_BAD     = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    WAIT_IDLE = 3'b001,
    WAIT_READ = 3'b010,
    WAIT_SEEK = 3'b100
  } wait_e;

  typedef enum logic [1:0] {
    CFG_CLUSTER_SECTORS = 2'd0,
    CFG_FAT_START       = 2'd1,
    CFG_FAT_LENGTH      = 2'd2,
    CFG_DATA_START      = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0]  cluster_sectors;
    logic [31:0] fat_base;
    logic [31:0] fat_length;
    logic [31:0] data_base;
  } cfg_t;

  typedef struct packed {
    logic [27:0] first_cluster;
    logic [27:0] now_cluster;
    logic [7:0]  sector_in_cluster;
    logic [31:0] file_bytes;
    wait_e       mode;
    logic [31:0] sectors_left;
    logic [31:0] sectors_total;
    logic [7:0]  pending_step;
  } st_t;

  typedef struct packed {
    kind_e                 kind;
    status_e               status;
    logic [31:0]           sector_addr;
    logic [7:0]            chunk_sectors;
    logic [WORD_IDX_W-1:0] word_index;
    logic [31:0]           sectors_done;
    logic [31:0]           size_value;
    logic                  last;
  } res_t;

  typedef struct packed {
    res_t       r0;
    res_t       r1;
    logic [1:0] n;
  } step_t;

  function automatic res_t mk_done(status_e st, logic [31:0] done);
    res_t r;
    r              = '0;
    r.kind         = KIND_DONE;
    r.status       = st;
    r.sectors_done = done;
    r.last         = 1'b1;
    return r;
  endfunction

endpackage

[sv/fccw_step.sv]
// ----------------------------------------------------------------------------
// FAT32 cluster chain walker step logic
// Computes the next file position and up to two results for one request.
// ----------------------------------------------------------------------------
module fccw_step (
  input  logic [2:0]    op_i,
  input  logic [27:0]   open_cluster_num_i,
  input  logic [31:0]   open_bytes_i,
  input  logic [31:0]   sector_count_i,
  input  logic [31:0]   fat_entry_i,
  input  fccw_pkg::cfg_t cfg_i,
  input  fccw_pkg::st_t  st_i,
  output fccw_pkg::st_t  st_o,
  output fccw_pkg::step_t step_o
);
  import fccw_pkg::*;

  logic                 run_go;
  logic                 run_rd;
  logic [27:0]          run_c;
  logic [7:0]           run_s;
  logic [31:0]          run_l;
  logic [31:0]          run_t;
  logic [7:0]           cs;
  logic [7:0]           rem;
  logic [7:0]           chunk;
  logic                 run_zero;
  logic                 run_short;
  logic [31:0]          t_new;
  logic [31:0]          mul;
  logic [31:0]          addr;
  logic                 fat_oob;
  logic [27:0]          entry;
  logic                 in_read;
  res_t                 lk;

  assign cs      = (cfg_i.cluster_sectors > MAX_CLUSTER_SECTORS) ? MAX_CLUSTER_SECTORS
                                                                  : cfg_i.cluster_sectors;
  assign entry   = fat_entry_i[27:0];
  assign in_read = (st_i.mode == WAIT_READ);

  always_comb begin
    st_o   = st_i;
    step_o = '0;
    run_go = 1'b0;
    run_rd = 1'b0;
    run_c  = st_i.now_cluster;
    run_s  = st_i.sector_in_cluster;
    run_l  = st_i.sectors_left;
    run_t  = st_i.sectors_total;

    unique case (op_i)
      OP_OPEN: begin
        st_o.first_cluster     = open_cluster_num_i;
        st_o.file_bytes        = open_bytes_i;
        st_o.now_cluster       = open_cluster_num_i;
        st_o.sector_in_cluster = '0;
        st_o.mode              = WAIT_IDLE;
        step_o.r0              = mk_done(ST_OK, '0);
        step_o.n               = 2'd1;
      end
      OP_READ, OP_SEEK: begin
        if (st_i.first_cluster == '0) begin
          st_o.mode = WAIT_IDLE;
          step_o.r0 = mk_done(ST_NO_FILE, '0);
          step_o.n  = 2'd1;
        end else begin
          st_o.pending_step = '0;
          run_go            = 1'b1;
          run_rd            = (op_i == OP_READ);
          run_l             = sector_count_i;
          run_t             = '0;
        end
      end
      OP_REPLY: begin
        if (st_i.mode != WAIT_IDLE) begin
          if (entry >= EOC_MIN) begin
            st_o.sector_in_cluster = cs;
            if (!in_read) begin
              st_o.sectors_left = '0;
            end
            st_o.mode = WAIT_IDLE;
            step_o.r0 = mk_done(ST_OK, in_read ? st_i.sectors_total : '0);
            step_o.n  = 2'd1;
          end else if (entry < MIN_CLUSTER || entry == BAD_MARK) begin
            st_o.mode = WAIT_IDLE;
            step_o.r0 = mk_done(ST_BAD, in_read ? st_i.sectors_total : '0);
            step_o.n  = 2'd1;
          end else begin
            st_o.now_cluster = entry;
            run_go           = 1'b1;
            run_rd           = in_read;
            run_c            = entry;
            run_s            = '0;
            run_l            = in_read ? st_i.sectors_left
                                       : st_i.sectors_left - {24'd0, st_i.pending_step};
          end
        end
      end
      OP_REWIND: begin
        st_o.now_cluster       = st_i.first_cluster;
        st_o.sector_in_cluster = '0;
        st_o.mode              = WAIT_IDLE;
        step_o.r0              = mk_done(ST_OK, '0);
        step_o.n               = 2'd1;
      end
      OP_SIZE: begin
        if (st_i.first_cluster == '0) begin
          step_o.r0 = mk_done(ST_NO_FILE, '0);
        end else begin
          step_o.r0            = mk_done(ST_OK, '0);
          step_o.r0.size_value = st_i.file_bytes;
        end
        step_o.n = 2'd1;
      end
      default: begin
      end
    endcase

    rem       = cs - run_s;
    run_zero  = (run_l == '0) || (run_s >= cs);
    run_short = run_l < {24'd0, rem};
    chunk     = run_short ? run_l[7:0] : rem;
    t_new     = run_t + {24'd0, chunk};
    mul       = {24'd0, cs} * ({4'd0, run_c} - CLUSTER_BASE);
    addr      = cfg_i.data_base + mul + {24'd0, run_s};
    fat_oob   = {{(32-FAT_IDX_W){1'b0}}, run_c[27:WORD_IDX_W]} >= cfg_i.fat_length;

    lk             = '0;
    lk.kind        = KIND_LOOKUP;
    lk.status      = ST_OK;
    lk.sector_addr = cfg_i.fat_base + {{(32-FAT_IDX_W){1'b0}}, run_c[27:WORD_IDX_W]};
    lk.word_index  = run_c[WORD_IDX_W-1:0];
    lk.last        = 1'b1;

    if (run_go) begin
      st_o.sector_in_cluster = run_s;
      st_o.sectors_left      = run_l;
      st_o.sectors_total     = run_t;
      st_o.mode              = WAIT_IDLE;
      if (run_zero) begin
        step_o.r0 = mk_done(ST_OK, run_rd ? run_t : '0);
        step_o.n  = 2'd1;
      end else if (run_rd) begin
        step_o.r0.kind          = KIND_READ;
        step_o.r0.status        = ST_OK;
        step_o.r0.sector_addr   = addr;
        step_o.r0.chunk_sectors = chunk;
        step_o.n                = 2'd2;
        st_o.sectors_left       = run_l - {24'd0, chunk};
        st_o.sectors_total      = t_new;
        if (run_short) begin
          st_o.sector_in_cluster = run_s + chunk;
          step_o.r1              = mk_done(ST_OK, t_new);
        end else if (fat_oob) begin
          step_o.r1 = mk_done(ST_BAD, t_new);
        end else begin
          step_o.r1 = lk;
          st_o.mode = WAIT_READ;
        end
      end else begin
        step_o.n = 2'd1;
        if (run_short) begin
          st_o.sector_in_cluster = run_s + run_l[7:0];
          st_o.sectors_left      = '0;
          step_o.r0              = mk_done(ST_OK, '0);
        end else begin
          st_o.pending_step = rem;
          if (fat_oob) begin
            step_o.r0 = mk_done(ST_BAD, '0);
          end else begin
            step_o.r0 = lk;
            st_o.mode = WAIT_SEEK;
          end
        end
      end
    end
  end

endmodule

[sv/fccw_res_fifo.sv]
// ----------------------------------------------------------------------------
// FAT32 cluster chain walker result queue
// Four-entry result queue that takes up to two results per cycle.
// ----------------------------------------------------------------------------
module fccw_res_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  fccw_pkg::step_t  push_i,
  input  logic             push_en_i,
  input  logic             pop_i,
  output fccw_pkg::res_t   head_o,
  output logic             valid_o,
  output logic [2:0]       count_o
);
  import fccw_pkg::*;

  res_t       mem_q [4];
  logic [1:0] wr_q, wr_d;
  logic [1:0] rd_q, rd_d;
  logic [2:0] cnt_q, cnt_d;
  logic [1:0] n_in;
  logic       do_pop;

  assign n_in    = push_en_i ? push_i.n : 2'd0;
  assign do_pop  = pop_i && (cnt_q != 3'd0);
  assign wr_d    = wr_q + n_in;
  assign rd_d    = rd_q + {1'b0, do_pop};
  assign cnt_d   = cnt_q + {1'b0, n_in} - {2'd0, do_pop};
  assign head_o  = mem_q[rd_q];
  assign valid_o = (cnt_q != 3'd0);
  assign count_o = cnt_q;

  always_ff @(posedge clk_i) begin
    if (n_in != 2'd0) begin
      mem_q[wr_q] <= push_i.r0;
    end
    if (n_in == 2'd2) begin
      mem_q[wr_q + 2'd1] <= push_i.r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

[sv/fat_cluster_chain_sector_walker.sv]
// ----------------------------------------------------------------------------
// FAT32 cluster chain sector walker
// Tracks the position in an open file and issues disk reads and FAT lookups.
// ----------------------------------------------------------------------------
// Usage: the configuration channel writes sectors per cluster, FAT start, FAT
// length and data start while the block is idle; it is always ready. Requests
// enter on the s_axis channel with the operation in tuser and arrive as open,
// read, seek, FAT reply, rewind or size query. Results leave on the m_axis
// channel with the result kind in tuser and tlast on the final result of a
// request. A read that reaches a cluster end gives a disk read and then a FAT
// lookup; the caller answers the lookup with a FAT reply request.
// Throughput: one request per cycle while the result queue has room. A request
// is held in an input register, its results are computed combinationally and
// written to a four-entry result queue, and the first result is valid on m_axis
// once it is in the queue. A request with two results holds the output port for
// both of them, so the output port sets the rate.
// The input stops while the queue holds three or more results, so a stalled
// receiver backs up into s_axis_tready after a few requests.
// Reset closes the file, clears the position and loads the register defaults.
// ----------------------------------------------------------------------------
module fat_cluster_chain_sector_walker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // open_cluster_num[27:0], open_bytes[59:28], sector_count[91:60],
  // fat_entry[123:92], zero fill.
  input  logic [fccw_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // op[2:0].
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status[1:0], sector_addr[33:2], chunk_sectors[41:34], word_index[48:42],
  // sectors_done[80:49], size_value[112:81], zero fill.
  output logic [fccw_pkg::M_TDATA_W-1:0] m_axis_tdata,
  // kind[1:0].
  output logic [1:0]  m_axis_tuser,
  output logic        m_axis_tlast
);
  import fccw_pkg::*;

  cfg_t        cfg_q;
  st_t         st_q, st_d;
  logic        in_valid_q;
  logic [2:0]  in_op_q;
  logic [123:0] in_data_q;
  step_t       step;
  res_t        head;
  logic        head_valid;
  logic [2:0]  q_count;
  logic        room;
  logic        step_fire;

  assign cfg_ready_o   = 1'b1;
  assign room          = (q_count <= 3'd2);
  assign step_fire     = in_valid_q && room;
  assign s_axis_tready = !in_valid_q || room;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cluster_sectors <= 8'd1;
      cfg_q.fat_base        <= '0;
      cfg_q.fat_length      <= 32'd1;
      cfg_q.data_base       <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_CLUSTER_SECTORS: cfg_q.cluster_sectors <= cfg_data_i[7:0];
        CFG_FAT_START:       cfg_q.fat_base        <= cfg_data_i;
        CFG_FAT_LENGTH:      cfg_q.fat_length      <= cfg_data_i;
        CFG_DATA_START:      cfg_q.data_base       <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_op_q   <= s_axis_tuser;
      in_data_q <= s_axis_tdata[123:0];
    end
  end

  fccw_step u_step (
    .op_i               (in_op_q),
    .open_cluster_num_i (in_data_q[27:0]),
    .open_bytes_i       (in_data_q[59:28]),
    .sector_count_i     (in_data_q[91:60]),
    .fat_entry_i        (in_data_q[123:92]),
    .cfg_i              (cfg_q),
    .st_i               (st_q),
    .st_o               (st_d),
    .step_o             (step)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.first_cluster     <= '0;
      st_q.now_cluster       <= '0;
      st_q.sector_in_cluster <= '0;
      st_q.file_bytes        <= '0;
      st_q.mode              <= WAIT_IDLE;
      st_q.sectors_left      <= '0;
      st_q.sectors_total     <= '0;
      st_q.pending_step      <= '0;
    end else if (step_fire) begin
      st_q <= st_d;
    end
  end

  fccw_res_fifo u_res_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (step),
    .push_en_i (step_fire),
    .pop_i     (m_axis_tready),
    .head_o    (head),
    .valid_o   (head_valid),
    .count_o   (q_count)
  );

  assign m_axis_tvalid = head_valid;
  assign m_axis_tuser  = head.kind;
  assign m_axis_tlast  = head.last;
  assign m_axis_tdata  = {7'd0, head.size_value, head.sectors_done, head.word_index,
                          head.chunk_sectors, head.sector_addr, head.status};

  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_count <= 3'd4)
    else $error("result queue overflow");

  a_hold_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !room |=> in_valid_q && $stable(in_op_q))
    else $error("blocked request lost");

  a_wait_needs_file: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.mode != WAIT_IDLE |-> st_q.first_cluster != '0)
    else $error("lookup pending without open file");

  a_sector_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.sector_in_cluster <= MAX_CLUSTER_SECTORS)
    else $error("sector position beyond cluster");

  a_read_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == KIND_READ |-> !m_axis_tlast)
    else $error("disk read marked as final result");

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cluster chain sector walker testbench
// Drives open, read, seek, FAT reply, rewind and size query requests into the
// walker, predicts the disk reads, FAT lookups and completions of each request
// and compares every result field with the prediction. Directed cases come
// first, then FAT chains with random content under several layouts, with
// random idling on both sides and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb;
  import fccw_pkg::*;

  localparam int          STALL_LIMIT = 2000;
  localparam logic [2:0]  OP_UNUSED_A = 3'd6;
  localparam logic [2:0]  OP_UNUSED_B = 3'd7;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid = 1'b0;
  cfg_idx_e    cfg_index = CFG_CLUSTER_SECTORS;
  logic [31:0] cfg_data = '0;
  logic        cfg_ready;
  logic        s_valid = 1'b0;
  logic [S_TDATA_W-1:0] s_data = '0;
  logic [2:0]  s_user = '0;
  logic        s_ready;
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [M_TDATA_W-1:0] m_data;
  logic [1:0]  m_user;
  logic        m_last;

  logic        hold_rx = 1'b0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          fails = 0;
  int          quiet = 0;

  // Predicted walker state and layout registers.
  logic [7:0]  c_spc = 8'd1;
  logic [31:0] c_fat_base = '0;
  logic [31:0] c_fat_len = 32'd1;
  logic [31:0] c_data_base = '0;
  logic [27:0] f_first = '0;
  logic [27:0] f_cluster = '0;
  logic [7:0]  f_sector = '0;
  logic [31:0] f_bytes = '0;
  wait_e       f_mode = WAIT_IDLE;
  logic [31:0] f_left = '0;
  logic [31:0] f_total = '0;
  logic [7:0]  f_step = '0;

  res_t        due_results[$];
  res_t        due_head;

  always #5 clk_i = ~clk_i;

  fat_cluster_chain_sector_walker dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .s_axis_tuser  (s_user),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data),
    .m_axis_tuser  (m_user),
    .m_axis_tlast  (m_last)
  );

  function automatic logic [7:0] spc_eff();
    return (c_spc > MAX_CLUSTER_SECTORS) ? MAX_CLUSTER_SECTORS : c_spc;
  endfunction

  function automatic void queue_result(kind_e k, status_e st, logic [31:0] addr,
                                       logic [7:0] chunk, logic [6:0] word,
                                       logic [31:0] done, logic [31:0] size,
                                       logic last);
    res_t r;
    r.kind          = k;
    r.status        = st;
    r.sector_addr   = addr;
    r.chunk_sectors = chunk;
    r.word_index    = word;
    r.sectors_done  = done;
    r.size_value    = size;
    r.last          = last;
    due_results.push_back(r);
  endfunction

  function automatic void walk_finish(status_e st);
    logic [31:0] done;
    done   = (f_mode == WAIT_READ) ? f_total : '0;
    f_mode = WAIT_IDLE;
    queue_result(KIND_DONE, st, '0, '0, '0, done, '0, 1'b1);
  endfunction

  function automatic void walk_lookup(wait_e m);
    logic [31:0] idx;
    idx    = {11'd0, f_cluster[27:7]};
    f_mode = m;
    if (idx >= c_fat_len) walk_finish(ST_BAD);
    else queue_result(KIND_LOOKUP, ST_OK, c_fat_base + idx, '0, f_cluster[6:0],
                      '0, '0, 1'b1);
  endfunction

  function automatic void walk_read();
    logic [7:0]  cs;
    logic [7:0]  rem;
    logic [7:0]  chunk;
    logic [31:0] addr;
    cs     = spc_eff();
    f_mode = WAIT_READ;
    if (f_left == '0 || f_sector >= cs) begin
      walk_finish(ST_OK);
      return;
    end
    rem   = cs - f_sector;
    chunk = (f_left < rem) ? f_left[7:0] : rem;
    addr  = c_data_base + {24'd0, cs} * ({4'd0, f_cluster} - CLUSTER_BASE)
            + {24'd0, f_sector};
    queue_result(KIND_READ, ST_OK, addr, chunk, '0, '0, '0, 1'b0);
    f_left  = f_left - chunk;
    f_total = f_total + chunk;
    if (chunk < rem) begin
      f_sector = f_sector + chunk;
      walk_finish(ST_OK);
    end else begin
      walk_lookup(WAIT_READ);
    end
  endfunction

  function automatic void walk_seek();
    logic [7:0] cs;
    logic [7:0] rem;
    cs     = spc_eff();
    f_mode = WAIT_SEEK;
    if (f_left == '0 || f_sector >= cs) begin
      walk_finish(ST_OK);
      return;
    end
    rem = cs - f_sector;
    if (f_left < rem) begin
      f_sector = f_sector + f_left[7:0];
      f_left   = '0;
      walk_finish(ST_OK);
    end else begin
      f_step = rem;
      walk_lookup(WAIT_SEEK);
    end
  endfunction

  function automatic void walk_reply(logic [31:0] raw);
    logic [27:0] e;
    logic        in_read;
    e       = raw[27:0];
    in_read = (f_mode == WAIT_READ);
    if (e >= EOC_MIN) begin
      f_sector = spc_eff();
      if (!in_read) f_left = '0;
      walk_finish(ST_OK);
    end else if (e < MIN_CLUSTER || e == BAD_MARK) begin
      walk_finish(ST_BAD);
    end else begin
      f_cluster = e;
      f_sector  = '0;
      if (in_read) begin
        walk_read();
      end else begin
        f_left = f_left - f_step;
        walk_seek();
      end
    end
  endfunction

  function automatic void walk_request(logic [2:0] op, logic [27:0] cl,
                                       logic [31:0] bytes, logic [31:0] cnt,
                                       logic [31:0] entry);
    case (op)
      OP_OPEN: begin
        f_first   = cl;
        f_bytes   = bytes;
        f_cluster = cl;
        f_sector  = '0;
        f_mode    = WAIT_IDLE;
        walk_finish(ST_OK);
      end
      OP_READ, OP_SEEK: begin
        if (f_first == '0) begin
          f_mode = WAIT_IDLE;
          walk_finish(ST_NO_FILE);
        end else begin
          f_left  = cnt;
          f_total = '0;
          f_step  = '0;
          if (op == OP_READ) walk_read();
          else walk_seek();
        end
      end
      OP_REPLY: begin
        if (f_mode != WAIT_IDLE) walk_reply(entry);
      end
      OP_REWIND: begin
        f_cluster = f_first;
        f_sector  = '0;
        f_mode    = WAIT_IDLE;
        walk_finish(ST_OK);
      end
      OP_SIZE: begin
        if (f_first == '0) queue_result(KIND_DONE, ST_NO_FILE, '0, '0, '0, '0, '0, 1'b1);
        else queue_result(KIND_DONE, ST_OK, '0, '0, '0, '0, f_bytes, 1'b1);
      end
      default: begin
      end
    endcase
  endfunction

  function automatic logic [27:0] cluster_top();
    logic [31:0] lim;
    if (c_fat_len > 32'h001f_ffff) lim = {4'd0, BAD_MARK} - 1;
    else if (c_fat_len == '0) lim = CLUSTER_BASE;
    else lim = c_fat_len * FAT_WORDS_PER_SECTOR - 1;
    if (lim < CLUSTER_BASE) lim = CLUSTER_BASE;
    return lim[27:0];
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fails++;
    end
  endfunction

  always @(posedge clk_i) begin
    if (m_valid && m_ready) begin
      if (due_results.size() == 0) begin
        $error("unexpected result: kind %0d, tdata 0x%0h", m_user, m_data);
        fails++;
      end else begin
        due_head = due_results.pop_front();
        check_field("kind", due_head.kind, m_user);
        check_field("status", due_head.status, m_data[1:0]);
        check_field("sector_addr", due_head.sector_addr, m_data[33:2]);
        check_field("chunk_sectors", due_head.chunk_sectors, m_data[41:34]);
        check_field("word_index", due_head.word_index, m_data[48:42]);
        check_field("sectors_done", due_head.sectors_done, m_data[80:49]);
        check_field("size_value", due_head.size_value, m_data[112:81]);
        check_field("last", due_head.last, m_last);
      end
    end
  end

  always @(posedge clk_i) begin
    m_ready <= !hold_rx && ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic send_request(logic [2:0] op, logic [27:0] cl, logic [31:0] bytes,
                              logic [31:0] cnt, logic [31:0] entry);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    s_valid <= 1'b1;
    s_data  <= {4'd0, entry, cnt, bytes, cl};
    s_user  <= op;
    do @(posedge clk_i); while (!s_ready);
    walk_request(op, cl, bytes, cnt, entry);
  endtask

  task automatic drain_results();
    s_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic cfg_write(cfg_idx_e idx, logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk_i); while (!cfg_ready);
    case (idx)
      CFG_CLUSTER_SECTORS: c_spc = value[7:0];
      CFG_FAT_START:       c_fat_base = value;
      CFG_FAT_LENGTH:      c_fat_len = value;
      CFG_DATA_START:      c_data_base = value;
      default: begin
      end
    endcase
  endtask

  task automatic set_layout(logic [31:0] spc, logic [31:0] fat_org,
                            logic [31:0] fat_len, logic [31:0] data_org);
    drain_results();
    cfg_write(CFG_CLUSTER_SECTORS, spc);
    cfg_write(CFG_FAT_START, fat_org);
    cfg_write(CFG_FAT_LENGTH, fat_len);
    cfg_write(CFG_DATA_START, data_org);
    cfg_valid <= 1'b0;
  endtask

  task automatic hold_receiver(int cycles);
    hold_rx <= 1'b1;
    repeat (cycles) @(posedge clk_i);
    hold_rx <= 1'b0;
  endtask

  task automatic random_request();
    logic [2:0]  op;
    logic [27:0] cl;
    logic [31:0] bytes;
    logic [31:0] cnt;
    logic [31:0] entry;
    int          roll;
    cl    = 28'($urandom);
    bytes = $urandom;
    cnt   = $urandom;
    entry = $urandom;
    roll  = $urandom_range(99);
    if (f_mode != WAIT_IDLE && roll < 75) begin
      op   = OP_REPLY;
      roll = $urandom_range(99);
      if (roll < 70) entry[27:0] = 28'($urandom_range(MIN_CLUSTER, cluster_top()));
      else if (roll < 80) entry[27:0] = EOC_MIN + 28'($urandom_range(7));
      else if (roll < 85) entry[27:0] = BAD_MARK;
      else if (roll < 90) entry[27:0] = 28'($urandom_range(1));
    end else if (f_first == '0 && roll < 70) begin
      op = OP_OPEN;
    end else begin
      roll = $urandom_range(99);
      if (roll < 38) op = OP_READ;
      else if (roll < 58) op = OP_SEEK;
      else if (roll < 66) op = OP_REWIND;
      else if (roll < 74) op = OP_SIZE;
      else if (roll < 86) op = OP_OPEN;
      else if (roll < 94) op = OP_REPLY;
      else if (roll < 97) op = OP_UNUSED_A;
      else op = OP_UNUSED_B;
    end
    if (op == OP_OPEN && $urandom_range(99) < 85)
      cl = 28'($urandom_range(MIN_CLUSTER, cluster_top()));
    if ((op == OP_READ || op == OP_SEEK) && $urandom_range(99) < 85)
      cnt = $urandom_range(3 * spc_eff() + 2);
    send_request(op, cl, bytes, cnt, entry);
  endtask

  task automatic random_traffic(int count);
    repeat (count) random_request();
    drain_results();
  endtask

  task automatic test_no_file();
    send_request(OP_SIZE, '0, '0, '0, '0);
    send_request(OP_READ, '0, '0, 32'd3, '0);
    send_request(OP_SEEK, '0, '0, 32'd3, '0);
    send_request(OP_REPLY, '0, '0, '0, 32'd5);
    send_request(OP_UNUSED_A, '0, '0, '0, '0);
    send_request(OP_UNUSED_B, '0, '0, '0, '0);
    send_request(OP_OPEN, '0, 32'hffff_ffff, '0, '0);
    send_request(OP_SIZE, '0, '0, '0, '0);
    drain_results();
  endtask

  task automatic test_unit_clusters();
    send_request(OP_OPEN, 28'hfff_ffff, '0, '0, '0);
    send_request(OP_READ, '0, '0, 32'd1, '0);
    send_request(OP_OPEN, 28'd5, 32'hffff_ffff, '0, '0);
    send_request(OP_SIZE, '0, '0, '0, '0);
    send_request(OP_READ, '0, '0, 32'hffff_ffff, '0);
    send_request(OP_REPLY, '0, '0, '0, 32'hf000_0006);
    send_request(OP_REPLY, '0, '0, '0, 32'hffff_ffff);
    send_request(OP_READ, '0, '0, 32'd4, '0);
    send_request(OP_SEEK, '0, '0, 32'd4, '0);
    drain_results();
  endtask

  task automatic test_chain_walk();
    set_layout(32'd4, 32'h10, 32'd2, 32'h800);
    send_request(OP_OPEN, 28'd130, 32'h1234, '0, '0);
    send_request(OP_READ, '0, '0, 32'd6, '0);
    send_request(OP_READ, '0, '0, 32'd2, '0);
    send_request(OP_SEEK, '0, '0, 32'd5, '0);
    send_request(OP_SIZE, '0, '0, '0, '0);
    send_request(OP_REPLY, '0, '0, '0, 32'd131);
    send_request(OP_REPLY, '0, '0, '0, 32'd7);
    send_request(OP_READ, '0, '0, 32'd3, '0);
    send_request(OP_REPLY, '0, '0, '0, {4'd0, BAD_MARK});
    send_request(OP_REWIND, '0, '0, '0, '0);
    send_request(OP_SEEK, '0, '0, 32'd4, '0);
    send_request(OP_REPLY, '0, '0, '0, 32'd1);
    send_request(OP_OPEN, 28'd300, '0, '0, '0);
    send_request(OP_READ, '0, '0, 32'd8, '0);
    drain_results();
  endtask

  task automatic test_cluster_size_limits();
    set_layout('0, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_fff0);
    send_request(OP_OPEN, 28'd2, '0, '0, '0);
    send_request(OP_READ, '0, '0, 32'd5, '0);
    send_request(OP_SEEK, '0, '0, 32'd5, '0);
    set_layout(32'hffff_ffff, 32'hffff_ffff, '0, 32'hffff_ffff);
    send_request(OP_REWIND, '0, '0, '0, '0);
    send_request(OP_READ, '0, '0, 32'd200, '0);
    drain_results();
  endtask

  task automatic test_random_no_idle();
    set_layout(32'd4, 32'd100, 32'd4, 32'd1000);
    send_idle_pct = 0;
    recv_stall_pct <= 0;
    random_traffic(125);
  endtask

  task automatic test_random_sender_idle();
    set_layout(32'd1, 32'hffff_ff00, 32'd1, 32'hffff_fff0);
    send_idle_pct = 58;
    recv_stall_pct <= 0;
    random_traffic(125);
  endtask

  task automatic test_random_receiver_stall();
    set_layout(32'd128, $urandom, 32'hffff_ffff, $urandom);
    send_idle_pct = 0;
    recv_stall_pct <= 58;
    random_traffic(125);
  endtask

  task automatic test_random_both_idle();
    set_layout({24'($urandom_range(2 ** 24 - 1)), 8'($urandom_range(8, 1))}, $urandom,
               $urandom_range(64, 1), $urandom);
    send_idle_pct = 15;
    recv_stall_pct <= 15;
    random_traffic(125);
  endtask

  task automatic test_backpressure();
    set_layout(32'd2, '0, 32'd16, 32'h100);
    send_idle_pct = 0;
    recv_stall_pct <= 0;
    fork
      hold_receiver(300);
      repeat (40) random_request();
    join
    drain_results();
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_no_file();
    test_unit_clusters();
    test_chain_walk();
    test_cluster_size_limits();
    test_random_no_idle();
    test_backpressure();
    test_random_sender_idle();
    test_random_receiver_stall();
    test_random_both_idle();
    drain_results();
    repeat (20) @(posedge clk_i);
    if (fails == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
